/* sv/framebuffer_fill_invert_blit_macros.svh */
// assertion macros for the drawing engine checker
`ifndef FRAMEBUFFER_FILL_INVERT_BLIT_MACROS_SVH
`define FRAMEBUFFER_FILL_INVERT_BLIT_MACROS_SVH

// same-cycle implication
`define FFIB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffib assertion failed");

// next-cycle implication
`define FFIB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffib assertion failed");

`endif

/* sv/ffib_pkg.sv */
// types and codes shared by the drawing engine modules
`default_nettype none
package ffib_pkg;

	localparam logic [2:0] ACT_CLEAR   = 3'd0;
	localparam logic [2:0] ACT_FILL    = 3'd1;
	localparam logic [2:0] ACT_OUTLINE = 3'd2;
	localparam logic [2:0] ACT_START   = 3'd3;
	localparam logic [2:0] ACT_BYTE    = 3'd4;
	localparam logic [2:0] ACT_READ    = 3'd5;

	localparam logic [1:0] PM_BG  = 2'd0;
	localparam logic [1:0] PM_FG  = 2'd1;
	localparam logic [1:0] PM_INV = 2'd2;
	localparam logic [1:0] PM_BAD = 2'd3;

	localparam logic CFG_FG = 1'b0;
	localparam logic CFG_BG = 1'b1;

	localparam logic [23:0] FG_RESET = 24'hFFFFFF;
	localparam logic [23:0] BG_RESET = 24'h404040;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  x_start;
		logic [7:0]  y_start;
		logic [7:0]  x_end;
		logic [7:0]  y_end;
		logic [7:0]  bitmap_width;
		logic [7:0]  bitmap_height;
		logic [1:0]  paint_mode;
		logic [7:0]  bitmap_byte;
	} in_item_t;

	typedef struct packed {
		logic [23:0] pixel_colour;
		logic        error;
		logic        blit_complete;
	} out_item_t;

	typedef enum logic [2:0] {
		CMD_CLEAR,
		CMD_FILL,
		CMD_OUTLINE,
		CMD_START,
		CMD_BYTE,
		CMD_READ,
		CMD_BAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      bad_mode;
		in_item_t  item;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEG,
		ST_PIX,
		ST_PIXW,
		ST_BYTE,
		ST_RDW,
		ST_FIN
	} back_state_t;

endpackage
`default_nettype wire

/* sv/ffib_front.sv */
// front end: accepts commands, classifies them and queues them for the back end
`default_nettype none
module ffib_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ffib_pkg::in_item_t in_item,
	output logic                   cmd_valid,
	output ffib_pkg::cmd_t         cmd,
	input  wire logic              cmd_pop
);

	ffib_pkg::cmd_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	ffib_pkg::cmd_t cls;
	logic           push;

	always_comb begin
		cls.item     = in_item;
		cls.bad_mode = 1'b0;
		case (in_item.action)
			ffib_pkg::ACT_CLEAR: begin
				cls.kind = ffib_pkg::CMD_CLEAR;
			end
			ffib_pkg::ACT_FILL: begin
				cls.kind     = ffib_pkg::CMD_FILL;
				cls.bad_mode = in_item.paint_mode == ffib_pkg::PM_BAD;
			end
			ffib_pkg::ACT_OUTLINE: begin
				cls.kind     = ffib_pkg::CMD_OUTLINE;
				cls.bad_mode = in_item.paint_mode == ffib_pkg::PM_BAD;
			end
			ffib_pkg::ACT_START: begin
				cls.kind     = ffib_pkg::CMD_START;
				cls.bad_mode = in_item.paint_mode == ffib_pkg::PM_INV
					|| in_item.paint_mode == ffib_pkg::PM_BAD;
			end
			ffib_pkg::ACT_BYTE: begin
				cls.kind = ffib_pkg::CMD_BYTE;
			end
			ffib_pkg::ACT_READ: begin
				cls.kind = ffib_pkg::CMD_READ;
			end
			default: begin
				cls.kind = ffib_pkg::CMD_BAD;
			end
		endcase
	end

	assign in_stall  = count_q[1];
	assign push      = in_valid && !in_stall;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule
`default_nettype wire

/* sv/ffib_back.sv */
// back end: pixel sequencer, frame memory, bitmap state and result register
`default_nettype none
module ffib_back #(
	parameter int SCREEN_WIDTH  = 160,
	parameter int SCREEN_HEIGHT = 80
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [23:0]        fg,
	input  wire logic [23:0]        bg,
	input  wire logic               cmd_valid,
	input  wire ffib_pkg::cmd_t     cmd,
	output logic                    cmd_pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output ffib_pkg::out_item_t     out_item
);

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [7:0] X_LAST = 8'(SCREEN_WIDTH - 1);
	localparam logic [7:0] Y_LAST = 8'(SCREEN_HEIGHT - 1);

	logic [23:0] mem [DEPTH];
	logic [23:0] rdata_q;

	ffib_pkg::back_state_t state_q, state_d;
	ffib_pkg::cmd_t cmd_q, cmd_d;
	logic [7:0]  cx_q, cx_d, cy_q, cy_d, x0_q, x0_d, x1_q, x1_d, y1_q, y1_d;
	logic [1:0]  seg_q, seg_d, pmode_q, pmode_d;
	logic        err_q, err_d, done_q, done_d;
	logic [23:0] colour_q, colour_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  org_x_q, org_x_d, org_y_q, org_y_d, bw_q, bw_d, bh_q, bh_d;
	logic [7:0]  col_q, col_d, row_q, row_d;
	logic        bmode_q, bmode_d, active_q, active_d;
	logic        out_valid_q;
	ffib_pkg::out_item_t out_q;
	logic        out_load;

	logic [8:0]  pix_x, pix_y;
	logic        on_screen;
	logic [ADDR_W-1:0] mem_addr;
	logic        mem_we;
	logic [23:0] mem_wdata;
	logic [7:0]  sx, sy, ex, ey;
	logic        row_end, rect_end, bit_set, bm_fg;
	logic [8:0]  row_next;

	always_comb begin
		case (state_q)
			ffib_pkg::ST_IDLE: begin
				pix_x = {1'b0, cmd.item.x_start};
				pix_y = {1'b0, cmd.item.y_start};
			end
			ffib_pkg::ST_BYTE: begin
				pix_x = {1'b0, org_x_q} + {1'b0, col_q};
				pix_y = {1'b0, org_y_q} + {1'b0, row_q};
			end
			default: begin
				pix_x = {1'b0, cx_q};
				pix_y = {1'b0, cy_q};
			end
		endcase
		on_screen = pix_x < 9'(SCREEN_WIDTH) && pix_y < 9'(SCREEN_HEIGHT);
		mem_addr  = ADDR_W'({24'd0, pix_y[7:0]} * SCREEN_WIDTH) + ADDR_W'(pix_x[7:0]);
	end

	// rectangle for the current segment
	always_comb begin
		sx = cmd_q.item.x_start;
		sy = cmd_q.item.y_start;
		ex = cmd_q.item.x_end;
		ey = cmd_q.item.y_end;
		if (cmd_q.kind == ffib_pkg::CMD_OUTLINE) begin
			case (seg_q)
				2'd0: ey = cmd_q.item.y_start;
				2'd1: sy = cmd_q.item.y_end;
				2'd2: ex = cmd_q.item.x_start;
				default: sx = cmd_q.item.x_end;
			endcase
		end
	end

	assign row_end  = cx_q == x1_q;
	assign rect_end = row_end && cy_q == y1_q;
	assign bit_set  = cmd_q.item.bitmap_byte[3'd7 - bit_q[2:0]];
	assign bm_fg    = bit_set ? bmode_q : !bmode_q;
	assign row_next = {1'b0, row_q} + 9'd1;
	assign out_load = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		cx_d     = cx_q;
		cy_d     = cy_q;
		x0_d     = x0_q;
		x1_d     = x1_q;
		y1_d     = y1_q;
		seg_d    = seg_q;
		pmode_d  = pmode_q;
		err_d    = err_q;
		done_d   = done_q;
		colour_d = colour_q;
		bit_d    = bit_q;
		org_x_d  = org_x_q;
		org_y_d  = org_y_q;
		bw_d     = bw_q;
		bh_d     = bh_q;
		col_d    = col_q;
		row_d    = row_q;
		bmode_d  = bmode_q;
		active_d = active_q;
		cmd_pop  = 1'b0;
		mem_we   = 1'b0;
		mem_wdata = bg;
		case (state_q)
			ffib_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop  = 1'b1;
					cmd_d    = cmd;
					err_d    = 1'b0;
					done_d   = 1'b0;
					colour_d = 24'd0;
					pmode_d  = cmd.item.paint_mode;
					bit_d    = 4'd0;
					state_d  = ffib_pkg::ST_FIN;
					if (cmd.kind == ffib_pkg::CMD_BAD || cmd.bad_mode) begin
						err_d = 1'b1;
						if (cmd.kind == ffib_pkg::CMD_START) begin
							active_d = 1'b0;
						end
					end else begin
						case (cmd.kind)
							ffib_pkg::CMD_CLEAR: begin
								x0_d    = 8'd0;
								cx_d    = 8'd0;
								cy_d    = 8'd0;
								x1_d    = X_LAST;
								y1_d    = Y_LAST;
								seg_d   = 2'd3;
								pmode_d = ffib_pkg::PM_BG;
								state_d = ffib_pkg::ST_PIX;
							end
							ffib_pkg::CMD_FILL: begin
								seg_d   = 2'd3;
								state_d = ffib_pkg::ST_SEG;
							end
							ffib_pkg::CMD_OUTLINE: begin
								seg_d   = 2'd0;
								state_d = ffib_pkg::ST_SEG;
							end
							ffib_pkg::CMD_START: begin
								active_d = cmd.item.bitmap_width != 8'd0
									&& cmd.item.bitmap_height != 8'd0;
								org_x_d  = cmd.item.x_start;
								org_y_d  = cmd.item.y_start;
								bw_d     = cmd.item.bitmap_width;
								bh_d     = cmd.item.bitmap_height;
								bmode_d  = cmd.item.paint_mode[0];
								col_d    = 8'd0;
								row_d    = 8'd0;
							end
							ffib_pkg::CMD_BYTE: begin
								if (active_q) begin
									state_d = ffib_pkg::ST_BYTE;
								end else begin
									err_d = 1'b1;
								end
							end
							ffib_pkg::CMD_READ: begin
								if (on_screen) begin
									state_d = ffib_pkg::ST_RDW;
								end else begin
									err_d = 1'b1;
								end
							end
							default: begin
								err_d = 1'b1;
							end
						endcase
					end
				end
			end
			ffib_pkg::ST_SEG: begin
				x0_d = sx;
				cx_d = sx;
				x1_d = ex;
				cy_d = sy;
				y1_d = ey;
				if (sx > ex || sy > ey) begin
					seg_d   = seg_q + 2'd1;
					state_d = (seg_q == 2'd3) ? ffib_pkg::ST_FIN : ffib_pkg::ST_SEG;
				end else begin
					state_d = ffib_pkg::ST_PIX;
				end
			end
			ffib_pkg::ST_PIX, ffib_pkg::ST_PIXW: begin
				if (state_q == ffib_pkg::ST_PIX && on_screen && pmode_q == ffib_pkg::PM_INV) begin
					state_d = ffib_pkg::ST_PIXW;
				end else begin
					if (!on_screen) begin
						err_d = 1'b1;
					end else begin
						mem_we = 1'b1;
						if (state_q == ffib_pkg::ST_PIXW) begin
							mem_wdata = (rdata_q == fg) ? bg : fg;
						end else begin
							mem_wdata = (pmode_q == ffib_pkg::PM_FG) ? fg : bg;
						end
					end
					if (row_end) begin
						cx_d = x0_q;
						cy_d = cy_q + 8'd1;
					end else begin
						cx_d = cx_q + 8'd1;
					end
					if (rect_end) begin
						seg_d   = seg_q + 2'd1;
						state_d = (seg_q == 2'd3) ? ffib_pkg::ST_FIN : ffib_pkg::ST_SEG;
					end else begin
						state_d = ffib_pkg::ST_PIX;
					end
				end
			end
			ffib_pkg::ST_BYTE: begin
				if (!bit_q[3] && col_q < bw_q) begin
					if (on_screen) begin
						mem_we    = 1'b1;
						mem_wdata = bm_fg ? fg : bg;
					end else begin
						err_d = 1'b1;
					end
					col_d = col_q + 8'd1;
					bit_d = bit_q + 4'd1;
				end else begin
					if (col_q >= bw_q) begin
						col_d = 8'd0;
						if (row_next >= {1'b0, bh_q}) begin
							row_d    = 8'd0;
							active_d = 1'b0;
							done_d   = 1'b1;
						end else begin
							row_d = row_next[7:0];
						end
					end
					state_d = ffib_pkg::ST_FIN;
				end
			end
			ffib_pkg::ST_RDW: begin
				colour_d = rdata_q;
				state_d  = ffib_pkg::ST_FIN;
			end
			ffib_pkg::ST_FIN: begin
				if (out_load) begin
					state_d = ffib_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffib_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffib_pkg::ST_IDLE;
			cmd_q       <= '0;
			cx_q        <= 8'd0;
			cy_q        <= 8'd0;
			x0_q        <= 8'd0;
			x1_q        <= 8'd0;
			y1_q        <= 8'd0;
			seg_q       <= 2'd0;
			pmode_q     <= 2'd0;
			err_q       <= 1'b0;
			done_q      <= 1'b0;
			colour_q    <= 24'd0;
			bit_q       <= 4'd0;
			org_x_q     <= 8'd0;
			org_y_q     <= 8'd0;
			bw_q        <= 8'd0;
			bh_q        <= 8'd0;
			col_q       <= 8'd0;
			row_q       <= 8'd0;
			bmode_q     <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q  <= state_d;
			cmd_q    <= cmd_d;
			cx_q     <= cx_d;
			cy_q     <= cy_d;
			x0_q     <= x0_d;
			x1_q     <= x1_d;
			y1_q     <= y1_d;
			seg_q    <= seg_d;
			pmode_q  <= pmode_d;
			err_q    <= err_d;
			done_q   <= done_d;
			colour_q <= colour_d;
			bit_q    <= bit_d;
			org_x_q  <= org_x_d;
			org_y_q  <= org_y_d;
			bw_q     <= bw_d;
			bh_q     <= bh_d;
			col_q    <= col_d;
			row_q    <= row_d;
			bmode_q  <= bmode_d;
			active_q <= active_d;
			if (state_q == ffib_pkg::ST_FIN && out_load) begin
				out_valid_q         <= 1'b1;
				out_q.pixel_colour  <= colour_q;
				out_q.error         <= err_q;
				out_q.blit_complete <= done_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

/* sv/framebuffer_fill_invert_blit.sv */
// top level of the drawing engine: color registers, front end and back end
// Commands enter a two-deep queue and are carried out one at a time by the
// pixel sequencer over a single-port frame memory, one result per command.
// Invert reads each pixel and then writes it on the same port; clear, fill,
// outline and bitmap pixels are only written. A read waits for the registered
// memory data before its result, and every command passes through decode and
// a result handoff. The frame memory is not cleared at reset.
`default_nettype none
module framebuffer_fill_invert_blit #(
	parameter int SCREEN_WIDTH  = 160,
	parameter int SCREEN_HEIGHT = 80
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire ffib_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ffib_pkg::out_item_t      out_item,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [23:0]         cfg_data
);

	logic [23:0]    fg_q;
	logic [23:0]    bg_q;
	logic           cmd_valid;
	logic           cmd_pop;
	ffib_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= ffib_pkg::FG_RESET;
			bg_q <= ffib_pkg::BG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == ffib_pkg::CFG_FG) begin
				fg_q <= cfg_data;
			end else begin
				bg_q <= cfg_data;
			end
		end
	end

	ffib_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ffib_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fg        (fg_q),
		.bg        (bg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

/* sv/ffib_checker.sv */
// port-level checker for the drawing engine, bound to the top level
`default_nettype none
`include "framebuffer_fill_invert_blit_macros.svh"
module ffib_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire ffib_pkg::out_item_t out_item
);

	// a stalled result transfer keeps its valid and payload
	`FFIB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`FFIB_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item))
	// only a good read returns a color
	`FFIB_ASSERT_NOW(a_colour_no_done, out_valid && out_item.pixel_colour != 24'd0, !out_item.blit_complete)
	`FFIB_ASSERT_NOW(a_colour_no_err, out_valid && out_item.pixel_colour != 24'd0, !out_item.error)

endmodule

bind framebuffer_fill_invert_blit ffib_checker u_ffib_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for the drawing engine: directed table, then random commands
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam int SCR_W = 160;
	localparam int SCR_H = 80;
	localparam int NUM_RANDOM = 1700;
	localparam int QUIET_TAIL = 200;
	localparam int STALL_LIMIT = 400000;
	localparam logic [2:0] ACT_BAD6 = 3'd6;
	localparam logic [2:0] ACT_BAD7 = 3'd7;

	typedef struct {
		ffib_pkg::in_item_t  cmd;
		bit                  typed;
		ffib_pkg::out_item_t res;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	ffib_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_stall;
	ffib_pkg::out_item_t out_item;
	logic                cfg_we;
	logic                cfg_index;
	logic [23:0]         cfg_data;

	// predictor state
	logic [23:0] pix_mem [0:SCR_W*SCR_H-1];
	logic [23:0] fg_q;
	logic [23:0] bg_q;
	int          blit_x, blit_y, blit_w, blit_h, blit_col, blit_row;
	logic        blit_mode;
	bit          blit_on;

	ffib_pkg::out_item_t pending_results[$];
	int                  mismatches;
	int                  cmds_sent;
	bit                  quiet;
	int                  idle_cycles;

	framebuffer_fill_invert_blit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit paint(int x, int y, logic [1:0] m);
		int idx;
		if (x >= SCR_W || y >= SCR_H)
			return 1'b1;
		idx = y * SCR_W + x;
		case (m)
			ffib_pkg::PM_BG: pix_mem[idx] = bg_q;
			ffib_pkg::PM_FG: pix_mem[idx] = fg_q;
			default: pix_mem[idx] = (pix_mem[idx] == fg_q) ? bg_q : fg_q;
		endcase
		return 1'b0;
	endfunction

	function automatic bit fill_rect(int x0, int y0, int x1, int y1, logic [1:0] m);
		bit err;
		err = 1'b0;
		for (int y = y0; y <= y1; y++)
			for (int x = x0; x <= x1; x++)
				if (paint(x, y, m))
					err = 1'b1;
		return err;
	endfunction

	function automatic ffib_pkg::out_item_t draw_predict(ffib_pkg::in_item_t it);
		ffib_pkg::out_item_t r;
		bit                  set;
		logic [1:0]          pm;
		r = '0;
		case (it.action)
			ffib_pkg::ACT_CLEAR: begin
				for (int i = 0; i < SCR_W * SCR_H; i++)
					pix_mem[i] = bg_q;
			end
			ffib_pkg::ACT_FILL: begin
				if (it.paint_mode == ffib_pkg::PM_BAD)
					r.error = 1'b1;
				else
					r.error = fill_rect(it.x_start, it.y_start, it.x_end, it.y_end,
						it.paint_mode);
			end
			ffib_pkg::ACT_OUTLINE: begin
				if (it.paint_mode == ffib_pkg::PM_BAD) begin
					r.error = 1'b1;
				end else begin
					if (fill_rect(it.x_start, it.y_start, it.x_end, it.y_start,
						it.paint_mode)) r.error = 1'b1;
					if (fill_rect(it.x_start, it.y_end, it.x_end, it.y_end,
						it.paint_mode)) r.error = 1'b1;
					if (fill_rect(it.x_start, it.y_start, it.x_start, it.y_end,
						it.paint_mode)) r.error = 1'b1;
					if (fill_rect(it.x_end, it.y_start, it.x_end, it.y_end,
						it.paint_mode)) r.error = 1'b1;
				end
			end
			ffib_pkg::ACT_START: begin
				blit_on = 1'b0;
				if (it.paint_mode > ffib_pkg::PM_FG) begin
					r.error = 1'b1;
				end else if (it.bitmap_width != 0 && it.bitmap_height != 0) begin
					blit_x = it.x_start;
					blit_y = it.y_start;
					blit_w = it.bitmap_width;
					blit_h = it.bitmap_height;
					blit_mode = it.paint_mode[0];
					blit_col = 0;
					blit_row = 0;
					blit_on = 1'b1;
				end
			end
			ffib_pkg::ACT_BYTE: begin
				if (!blit_on) begin
					r.error = 1'b1;
				end else begin
					for (int i = 0; i < 8 && blit_col < blit_w; i++) begin
						set = it.bitmap_byte[7-i];
						pm = set ? {1'b0, blit_mode} : {1'b0, ~blit_mode};
						if (paint(blit_x + blit_col, blit_y + blit_row, pm))
							r.error = 1'b1;
						blit_col++;
					end
					if (blit_col >= blit_w) begin
						blit_col = 0;
						blit_row++;
						if (blit_row >= blit_h) begin
							blit_row = 0;
							blit_on = 1'b0;
							r.blit_complete = 1'b1;
						end
					end
				end
			end
			ffib_pkg::ACT_READ: begin
				if (it.x_start < SCR_W && it.y_start < SCR_H)
					r.pixel_colour = pix_mem[it.y_start * SCR_W + it.x_start];
				else
					r.error = 1'b1;
			end
			default: r.error = 1'b1;
		endcase
		return r;
	endfunction

	function automatic ffib_pkg::in_item_t cmd(logic [2:0] a, int xs, int ys, int xe,
		int ye, int bw, int bh, logic [1:0] pm, int bb);
		ffib_pkg::in_item_t it;
		it.action = a;
		it.x_start = xs[7:0];
		it.y_start = ys[7:0];
		it.x_end = xe[7:0];
		it.y_end = ye[7:0];
		it.bitmap_width = bw[7:0];
		it.bitmap_height = bh[7:0];
		it.paint_mode = pm;
		it.bitmap_byte = bb[7:0];
		return it;
	endfunction

	function automatic ffib_pkg::out_item_t res(logic [23:0] c, logic e, logic d);
		ffib_pkg::out_item_t r;
		r.pixel_colour = c;
		r.error = e;
		r.blit_complete = d;
		return r;
	endfunction

	function automatic ffib_pkg::in_item_t rand_item();
		ffib_pkg::in_item_t it;
		logic [63:0]        raw;
		raw = {$urandom, $urandom};
		it = raw[$bits(ffib_pkg::in_item_t)-1:0];
		return it;
	endfunction

	task automatic send(ffib_pkg::in_item_t it, bit typed, ffib_pkg::out_item_t want);
		ffib_pkg::out_item_t p;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall !== 1'b0);
		p = draw_predict(it);
		pending_results.push_back(typed ? want : p);
		cmds_sent++;
		@(negedge clk);
	endtask

	task automatic send_p(ffib_pkg::in_item_t it);
		send(it, 1'b0, '0);
	endtask

	task automatic load_palette(logic [23:0] fg, logic [23:0] bg);
		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending_results.size() == 0);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ffib_pkg::CFG_FG;
		cfg_data <= fg;
		@(negedge clk);
		cfg_index <= ffib_pkg::CFG_BG;
		cfg_data <= bg;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= 24'($urandom);
		fg_q = fg;
		bg_q = bg;
		@(negedge clk);
	endtask

	task automatic rand_rect(inout ffib_pkg::in_item_t it);
		int r, ye;
		r = $urandom_range(0, 99);
		if (r == 0) begin
			it.x_end = 8'($urandom);
			it.y_end = 8'($urandom);
			it.x_start = 8'($urandom_range(0, 255));
			it.y_start = 8'($urandom_range(0, 255));
		end else if (r < 8) begin
			it.x_start = 8'($urandom_range(0, 255));
			it.y_start = 8'($urandom_range(0, 255));
			it.x_end = it.x_start - 8'($urandom_range(0, 4));
			ye = int'(it.y_start) + int'($urandom_range(0, 4));
			it.y_end = (ye > 255) ? 8'd255 : 8'(ye);
		end else begin
			it.x_start = 8'($urandom_range(0, 170));
			it.y_start = 8'($urandom_range(0, 88));
			it.x_end = it.x_start + 8'($urandom_range(0, 15));
			it.y_end = it.y_start + 8'($urandom_range(0, 10));
		end
	endtask

	task automatic run_random(int n);
		int goal, r, w, h, nb;
		ffib_pkg::in_item_t it;
		goal = cmds_sent + n;
		while (cmds_sent < goal) begin
			quiet = (NUM_RANDOM + 26 - cmds_sent) < QUIET_TAIL;
			r = $urandom_range(0, 99);
			it = rand_item();
			if (r < 35) begin
				w = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 20);
				h = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
				it.action = ffib_pkg::ACT_START;
				it.bitmap_width = 8'(w);
				it.bitmap_height = 8'(h);
				it.paint_mode = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1));
				if ($urandom_range(0, 3) == 0) it.x_start = 8'($urandom_range(0, 170));
				else it.x_start = 8'($urandom_range(0, 150));
				it.y_start = 8'($urandom_range(0, 85));
				send_p(it);
				nb = ((w + 7) / 8) * h;
				if (nb > 60 || $urandom_range(0, 9) == 0)
					nb = $urandom_range(1, 10);
				for (int i = 0; i < nb; i++) begin
					it = rand_item();
					it.action = ffib_pkg::ACT_BYTE;
					if ($urandom_range(0, 19) == 0)
						it.action = $urandom_range(0, 9) == 0 ? ffib_pkg::ACT_START
							: ffib_pkg::ACT_READ;
					send_p(it);
				end
			end else if (r < 55) begin
				it.action = ffib_pkg::ACT_FILL;
				rand_rect(it);
				send_p(it);
			end else if (r < 70) begin
				it.action = ffib_pkg::ACT_OUTLINE;
				rand_rect(it);
				send_p(it);
			end else if (r < 90) begin
				it.action = ffib_pkg::ACT_READ;
				it.x_start = ($urandom_range(0, 9) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, SCR_W - 1));
				it.y_start = ($urandom_range(0, 9) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, SCR_H - 1));
				send_p(it);
			end else if (r < 92) begin
				it.action = ffib_pkg::ACT_CLEAR;
				send_p(it);
			end else if (r < 96) begin
				it.action = $urandom_range(0, 1) ? ACT_BAD6 : ACT_BAD7;
				send_p(it);
			end else begin
				it.action = ffib_pkg::ACT_BYTE;
				send_p(it);
			end
		end
	endtask

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		ffib_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", out_item);
			end else begin
				want = pending_results.pop_front();
				if (out_item.pixel_colour !== want.pixel_colour ||
					out_item.error !== want.error ||
					out_item.blit_complete !== want.blit_complete) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: colour %h/%h error %b/%b complete %b/%b",
							want.pixel_colour, out_item.pixel_colour, want.error,
							out_item.error, want.blit_complete, out_item.blit_complete);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		dir_row_t rows[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = ffib_pkg::CFG_FG;
		cfg_data = '0;
		cmds_sent = 0;
		quiet = 1'b0;
		fg_q = ffib_pkg::FG_RESET;
		bg_q = ffib_pkg::BG_RESET;
		blit_on = 1'b0;
		blit_x = 0; blit_y = 0; blit_w = 0; blit_h = 0;
		blit_col = 0; blit_row = 0; blit_mode = 1'b0;
		for (int i = 0; i < SCR_W * SCR_H; i++)
			pix_mem[i] = '0;

		rows.push_back('{cmd(ffib_pkg::ACT_BYTE, 0, 0, 0, 0, 1, 1, ffib_pkg::PM_BG, 8'hFF),
			1'b1, res(24'd0, 1'b1, 1'b0)});
		rows.push_back('{cmd(ACT_BAD6, 0, 0, 0, 0, 1, 1, ffib_pkg::PM_BG, 0), 1'b1,
			res(24'd0, 1'b1, 1'b0)});
		rows.push_back('{cmd(ACT_BAD7, 255, 255, 255, 255, 255, 255, ffib_pkg::PM_BAD, 255),
			1'b1, res(24'd0, 1'b1, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, ffib_pkg::PM_BG, 0), 1'b1,
			res(24'd0, 1'b0, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, ffib_pkg::PM_BG, 0), 1'b1,
			res(ffib_pkg::BG_RESET, 1'b0, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_READ, 159, 79, 0, 0, 0, 0, ffib_pkg::PM_BG, 0), 1'b1,
			res(ffib_pkg::BG_RESET, 1'b0, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_READ, 160, 0, 0, 0, 0, 0, ffib_pkg::PM_BG, 0), 1'b1,
			res(24'd0, 1'b1, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_READ, 255, 255, 0, 0, 0, 0, ffib_pkg::PM_BG, 0),
			1'b1, res(24'd0, 1'b1, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_FILL, 0, 0, 10, 5, 0, 0, ffib_pkg::PM_FG, 0), 1'b1,
			res(24'd0, 1'b0, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_FILL, 0, 0, 10, 5, 0, 0, ffib_pkg::PM_BAD, 0), 1'b1,
			res(24'd0, 1'b1, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_FILL, 20, 0, 10, 5, 0, 0, ffib_pkg::PM_FG, 0), 1'b1,
			res(24'd0, 1'b0, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_FILL, 150, 70, 255, 90, 0, 0, ffib_pkg::PM_INV, 0),
			1'b0, '0});
		rows.push_back('{cmd(ffib_pkg::ACT_OUTLINE, 5, 3, 40, 30, 0, 0, ffib_pkg::PM_INV, 0),
			1'b0, '0});
		rows.push_back('{cmd(ffib_pkg::ACT_OUTLINE, 0, 0, 159, 79, 0, 0, ffib_pkg::PM_BG, 0),
			1'b0, '0});
		rows.push_back('{cmd(ffib_pkg::ACT_OUTLINE, 0, 0, 10, 5, 0, 0, ffib_pkg::PM_BAD, 0),
			1'b1, res(24'd0, 1'b1, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_READ, 5, 3, 0, 0, 0, 0, ffib_pkg::PM_BG, 0),
			1'b0, '0});
		rows.push_back('{cmd(ffib_pkg::ACT_START, 0, 0, 0, 0, 8, 8, ffib_pkg::PM_INV, 0), 1'b1,
			res(24'd0, 1'b1, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_START, 0, 0, 0, 0, 0, 4, ffib_pkg::PM_FG, 0), 1'b1,
			res(24'd0, 1'b0, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_START, 155, 78, 0, 0, 12, 3, ffib_pkg::PM_FG, 0),
			1'b1, res(24'd0, 1'b0, 1'b0)});
		for (int i = 0; i < 6; i++)
			rows.push_back('{cmd(ffib_pkg::ACT_BYTE, 0, 0, 0, 0, 0, 0, ffib_pkg::PM_BG,
				8'hA5 ^ (i * 37)), 1'b0, '0});
		rows.push_back('{cmd(ffib_pkg::ACT_START, 0, 0, 0, 0, 1, 1, ffib_pkg::PM_BG, 0), 1'b1,
			res(24'd0, 1'b0, 1'b0)});
		rows.push_back('{cmd(ffib_pkg::ACT_BYTE, 0, 0, 0, 0, 0, 0, ffib_pkg::PM_BG, 8'h80),
			1'b1, res(24'd0, 1'b0, 1'b1)});
		rows.push_back('{cmd(ffib_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, ffib_pkg::PM_BG, 0),
			1'b0, '0});

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send(rows[i].cmd, rows[i].typed, rows[i].res);

		run_random(NUM_RANDOM / 4);
		load_palette(24'h000000, 24'hFFFFFF);
		run_random(NUM_RANDOM / 4);
		load_palette(24'($urandom), 24'($urandom));
		run_random(NUM_RANDOM / 4);
		load_palette(24'h5A5A5A, 24'h5A5A5A);
		run_random(NUM_RANDOM / 8);
		load_palette(24'hFFFFFF, 24'h000000);
		run_random(NUM_RANDOM / 8);

		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (100) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
+incdir+sv
sv/ffib_pkg.sv
sv/ffib_front.sv
sv/ffib_back.sv
sv/framebuffer_fill_invert_blit.sv
sv/ffib_checker.sv
tb/tb_top.sv
